>>> src/rrva_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrva_pkg
// Shared types and constants of the round-robin voice allocator: payload
// structs, opcodes, command kinds and result status codes.
// ----------------------------------------------------------------------------
package rrva_pkg;

   localparam int VOICES      = 12;
   localparam int VIDX_W      = $clog2(VOICES);
   localparam int CNT_W       = $clog2(VOICES + 1);
   localparam int PITCH_W     = 7;
   localparam int MASK_W      = 12;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] OP_NOTE_ON  = 2'd0;
   localparam logic [1:0] OP_NOTE_OFF = 2'd1;
   localparam logic [1:0] OP_FREE_ALL = 2'd2;

   typedef enum logic [1:0] {
      CMD_NOTE_ON,
      CMD_NOTE_OFF,
      CMD_FREE_ALL,
      CMD_IGNORE
   } cmd_kind_type;

   typedef enum logic [2:0] {
      STATUS_STARTED      = 3'd0,
      STATUS_STOPPED      = 3'd1,
      STATUS_NO_FREE      = 3'd2,
      STATUS_NO_MATCH     = 3'd3,
      STATUS_NONE_RUNNING = 3'd4,
      STATUS_RESET_DONE   = 3'd5
   } status_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [PITCH_W-1:0] note_pitch;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]        result_status;
      logic [3:0]        voice_index;
      logic              voice_valid;
      logic [MASK_W-1:0] enable_mask;
      logic [3:0]        active_count;
   } rsp_payload_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [PITCH_W-1:0] pitch;
   } cmd_type;

   // Handshake between the front queue and the voice engine
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_chan_type;

endpackage
`default_nettype wire

>>> src/round_robin_voice_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_voice_allocator
// Hands synthesizer voices to note-on and note-off events by a rotating
// search, and frees all voices on command.
//
//   channel | ports                         | direction | transaction
//   req     | req_valid/ready, req_payload  | in        | op, note_pitch
//   rsp     | rsp_valid/ready, rsp_payload  | out       | status, voice, mask
//
// Each transaction passes through the scan and commit states of the voice engine;
// back-to-back commands chain from commit straight into the next scan.
// A two-entry command queue lets requests be taken while a result waits.
// Synchronous reset frees every voice at once; no clearing pass.
// A stalled result holds the engine in commit; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
module round_robin_voice_allocator (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rrva_pkg::req_payload_type req_payload,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output rrva_pkg::rsp_payload_type      rsp_payload
);

   rrva_pkg::cmd_chan_type cmd_chan;
   logic                   cmd_ready;

   rrva_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cmd_chan    (cmd_chan),
      .cmd_ready   (cmd_ready)
   );

   rrva_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd_chan    (cmd_chan),
      .cmd_ready   (cmd_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

>>> src/rrva_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrva_front
// Accepts request transactions, decodes the opcode into a command kind and
// holds decoded commands in a short queue for the voice engine.
// ----------------------------------------------------------------------------
module rrva_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire rrva_pkg::req_payload_type req_payload,
   output rrva_pkg::cmd_chan_type         cmd_chan,
   input  wire logic                      cmd_ready
);

   rrva_pkg::cmd_type               queue_ff [rrva_pkg::QUEUE_DEPTH];
   logic [rrva_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [rrva_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [rrva_pkg::QCNT_W-1:0]     count_ff, count_in;
   rrva_pkg::cmd_type               decoded;
   logic                            push, pop;

   always_comb begin
      decoded.pitch = req_payload.note_pitch;
      unique case (req_payload.op)
         rrva_pkg::OP_NOTE_ON:  decoded.kind = rrva_pkg::CMD_NOTE_ON;
         rrva_pkg::OP_NOTE_OFF: decoded.kind = rrva_pkg::CMD_NOTE_OFF;
         rrva_pkg::OP_FREE_ALL: decoded.kind = rrva_pkg::CMD_FREE_ALL;
         default:               decoded.kind = rrva_pkg::CMD_IGNORE;
      endcase
   end

   assign req_ready      = (count_ff != rrva_pkg::QCNT_W'(rrva_pkg::QUEUE_DEPTH));
   assign cmd_chan.valid = (count_ff != '0);
   assign cmd_chan.cmd   = queue_ff[rd_ptr_ff];
   assign push           = req_valid && req_ready;
   assign pop            = cmd_chan.valid && cmd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == rrva_pkg::QPTR_W'(rrva_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == rrva_pkg::QPTR_W'(rrva_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule
`default_nettype wire

>>> src/rrva_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rrva_engine
// Voice state and the circular search. A scan cycle builds the candidate
// vector rotated to the search start; a commit cycle picks the first
// candidate, updates the voices and loads the result register.
// ----------------------------------------------------------------------------
module rrva_engine (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rrva_pkg::cmd_chan_type cmd_chan,
   output logic                        cmd_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rrva_pkg::rsp_payload_type   rsp_payload
);

   localparam int PAD_W = (rrva_pkg::VOICES > rrva_pkg::MASK_W)
                          ? rrva_pkg::VOICES : rrva_pkg::MASK_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type                        state_ff;
   rrva_pkg::cmd_type                cmd_ff;
   logic [rrva_pkg::VOICES-1:0]      active_ff, active_in;
   logic [rrva_pkg::PITCH_W-1:0]     pitch_ff [rrva_pkg::VOICES];
   logic [rrva_pkg::VIDX_W-1:0]      last_ff, last_in;
   logic [rrva_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [rrva_pkg::VOICES-1:0]      rot_ff, rot_in;
   logic [rrva_pkg::VIDX_W-1:0]      start_ff, start_in;
   logic                             rsp_valid_ff;
   rrva_pkg::rsp_payload_type        rsp_ff, rsp_in;

   logic [rrva_pkg::VOICES-1:0]      cand;
   logic [2*rrva_pkg::VOICES-1:0]    cand_dbl;
   logic                             found;
   logic [rrva_pkg::VIDX_W-1:0]      offset;
   logic [rrva_pkg::VIDX_W:0]        pick_sum;
   logic [rrva_pkg::VIDX_W-1:0]      pick;
   logic                             pitch_wr;
   rrva_pkg::status_type             status_in;
   logic                             touched_in;
   logic [PAD_W-1:0]                 mask_pad;
   logic                             out_free;
   logic                             commit;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_COMMIT) && out_free;
   assign cmd_ready = (state_ff == ST_IDLE) || commit;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Scan: candidates and search start for the command held in cmd_ff
   always_comb begin
      if (cmd_ff.kind == rrva_pkg::CMD_NOTE_ON) begin
         start_in = (last_ff == rrva_pkg::VIDX_W'(rrva_pkg::VOICES - 1))
                    ? '0 : last_ff + 1'b1;
         cand     = ~active_ff;
      end else begin
         start_in = last_ff;
         for (int v = 0; v < rrva_pkg::VOICES; v++) begin
            cand[v] = active_ff[v] && (pitch_ff[v] == cmd_ff.pitch);
         end
      end
      cand_dbl = {cand, cand};
      rot_in   = rrva_pkg::VOICES'(cand_dbl >> start_in);
   end

   // Commit: first set bit of the rotated vector, mapped back to a voice
   always_comb begin
      found  = |rot_ff;
      offset = '0;
      for (int v = rrva_pkg::VOICES - 1; v >= 0; v--) begin
         if (rot_ff[v]) begin
            offset = rrva_pkg::VIDX_W'(v);
         end
      end
      pick_sum = {1'b0, start_ff} + {1'b0, offset};
      pick     = (pick_sum >= (rrva_pkg::VIDX_W + 1)'(rrva_pkg::VOICES))
                 ? rrva_pkg::VIDX_W'(pick_sum - (rrva_pkg::VIDX_W + 1)'(rrva_pkg::VOICES))
                 : pick_sum[rrva_pkg::VIDX_W-1:0];
   end

   always_comb begin
      active_in  = active_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      pitch_wr   = 1'b0;
      touched_in = 1'b0;
      status_in  = rrva_pkg::STATUS_NO_MATCH;
      unique case (cmd_ff.kind)
         rrva_pkg::CMD_NOTE_ON: begin
            if (found) begin
               active_in[pick] = 1'b1;
               last_in         = pick;
               count_in        = count_ff + 1'b1;
               pitch_wr        = 1'b1;
               touched_in      = 1'b1;
               status_in       = rrva_pkg::STATUS_STARTED;
            end else begin
               status_in = rrva_pkg::STATUS_NO_FREE;
            end
         end
         rrva_pkg::CMD_NOTE_OFF: begin
            if (count_ff == '0) begin
               status_in = rrva_pkg::STATUS_NONE_RUNNING;
            end else if (found) begin
               active_in[pick] = 1'b0;
               count_in        = count_ff - 1'b1;
               touched_in      = 1'b1;
               status_in       = rrva_pkg::STATUS_STOPPED;
            end
         end
         rrva_pkg::CMD_FREE_ALL: begin
            active_in = '0;
            count_in  = '0;
            status_in = rrva_pkg::STATUS_RESET_DONE;
         end
         rrva_pkg::CMD_IGNORE: begin
            status_in = rrva_pkg::STATUS_NO_MATCH;
         end
      endcase

      mask_pad                  = PAD_W'(active_in);
      rsp_in.result_status      = 3'(status_in);
      rsp_in.voice_index        = touched_in ? 4'(pick) : 4'd0;
      rsp_in.voice_valid        = touched_in;
      rsp_in.enable_mask        = mask_pad[rrva_pkg::MASK_W-1:0];
      rsp_in.active_count       = 4'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         active_ff    <= '0;
         last_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_chan.valid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (out_free) begin
                  active_ff    <= active_in;
                  last_ff      <= last_in;
                  count_ff     <= count_in;
                  // chain straight into the next scan when a command waits
                  state_ff     <= cmd_chan.valid ? ST_SCAN : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_chan.valid && cmd_ready) begin
         cmd_ff <= cmd_chan.cmd;
      end
      if (state_ff == ST_SCAN) begin
         rot_ff   <= rot_in;
         start_ff <= start_in;
      end
      if (commit) begin
         rsp_ff <= rsp_in;
         if (pitch_wr) begin
            pitch_ff[pick] <= cmd_ff.pitch;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      $countones(active_ff) == int'(count_ff))
      else $error("running count does not match active voices");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |=> state_ff == ST_COMMIT)
      else $error("scan not followed by commit");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_COMMIT))
      else $error("result raised outside commit");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.voice_valid |->
         (rsp_ff.result_status == 3'(rrva_pkg::STATUS_STARTED)) ||
         (rsp_ff.result_status == 3'(rrva_pkg::STATUS_STOPPED)))
      else $error("voice flagged on a result that touched none");

endmodule
`default_nettype wire

>>> sim/round_robin_voice_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// round_robin_voice_allocator_tb
// Self-checking bench for the voice allocator. A directed run fills and
// drains the voice pool and hits the no-free, no-match, none-running,
// free-all and unused-opcode cases. Random runs follow under changing
// idle and stall mixes, plus one long output hold-off. Every response is
// checked against an in-bench allocation predictor, in order.
// ----------------------------------------------------------------------------
module round_robin_voice_allocator_tb;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         DRAIN_WAIT  = 20;
   localparam int         PHASE_ITEMS = 240;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   rrva_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rrva_pkg::rsp_payload_type rsp_payload;

   rrva_pkg::req_payload_type pending_req_q[$];
   rrva_pkg::rsp_payload_type expected_rsp_q[$];

   // allocator state as the predictor sees it
   logic                           voice_on   [rrva_pkg::VOICES];
   logic [rrva_pkg::PITCH_W-1:0]   voice_note [rrva_pkg::VOICES];
   int                             last_used;
   int                             busy_count;

   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   int hold_len       = 0;
   int ready_hold_cnt = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   round_robin_voice_allocator u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic rrva_pkg::rsp_payload_type predict_allocation(
      rrva_pkg::req_payload_type req);
      rrva_pkg::rsp_payload_type res;
      int                        idx;
      logic                      found;
      res   = '0;
      found = 1'b0;
      case (req.op)
         rrva_pkg::OP_NOTE_ON: begin
            res.result_status = rrva_pkg::STATUS_NO_FREE;
            if (busy_count < rrva_pkg::VOICES) begin
               idx = (last_used + 1) % rrva_pkg::VOICES;
               for (int j = 0; j < rrva_pkg::VOICES; j++) begin
                  if (!found && !voice_on[idx]) begin
                     found              = 1'b1;
                     voice_on[idx]      = 1'b1;
                     voice_note[idx]    = req.note_pitch;
                     last_used          = idx;
                     busy_count++;
                     res.result_status  = rrva_pkg::STATUS_STARTED;
                     res.voice_index    = 4'(idx);
                     res.voice_valid    = 1'b1;
                  end
                  idx = (idx + 1) % rrva_pkg::VOICES;
               end
            end
         end
         rrva_pkg::OP_NOTE_OFF: begin
            if (busy_count == 0) begin
               res.result_status = rrva_pkg::STATUS_NONE_RUNNING;
            end else begin
               res.result_status = rrva_pkg::STATUS_NO_MATCH;
               // search starts at the last started voice itself
               idx = last_used;
               for (int j = 0; j < rrva_pkg::VOICES; j++) begin
                  if (!found && voice_on[idx] && voice_note[idx] == req.note_pitch) begin
                     found             = 1'b1;
                     voice_on[idx]     = 1'b0;
                     busy_count--;
                     res.result_status = rrva_pkg::STATUS_STOPPED;
                     res.voice_index   = 4'(idx);
                     res.voice_valid   = 1'b1;
                  end
                  idx = (idx + 1) % rrva_pkg::VOICES;
               end
            end
         end
         rrva_pkg::OP_FREE_ALL: begin
            for (int v = 0; v < rrva_pkg::VOICES; v++) voice_on[v] = 1'b0;
            busy_count        = 0;
            res.result_status = rrva_pkg::STATUS_RESET_DONE;
         end
         default: begin
            res.result_status = rrva_pkg::STATUS_NO_MATCH;
         end
      endcase
      for (int v = 0; v < rrva_pkg::VOICES && v < rrva_pkg::MASK_W; v++)
         res.enable_mask[v] = voice_on[v];
      res.active_count = 4'(busy_count);
      return res;
   endfunction

   function automatic void queue_request(logic [1:0] op,
                                         logic [rrva_pkg::PITCH_W-1:0] pitch);
      rrva_pkg::req_payload_type req;
      req.op         = op;
      req.note_pitch = pitch;
      pending_req_q.push_back(req);
   endfunction

   function automatic void queue_random_request();
      int                           r;
      logic [rrva_pkg::PITCH_W-1:0] pitch;
      r = $urandom_range(99);
      // a small pitch pool keeps note-offs matching most of the time
      if ($urandom_range(3) != 0) pitch = rrva_pkg::PITCH_W'(48 + $urandom_range(15));
      else                        pitch = rrva_pkg::PITCH_W'($urandom_range(127));
      if (r < 55)      queue_request(rrva_pkg::OP_NOTE_ON, pitch);
      else if (r < 90) queue_request(rrva_pkg::OP_NOTE_OFF, pitch);
      else if (r < 96) queue_request(rrva_pkg::OP_FREE_ALL, pitch);
      else             queue_request(OP_UNUSED, pitch);
   endfunction

   task automatic wait_drained();
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
   endtask

   // driver: predict on acceptance, then offer the next pending transaction
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp_q.push_back(predict_allocation(req_payload));
         if (!req_valid || req_ready) begin
            if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid   <= 1'b1;
               req_payload <= pending_req_q.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response ready, with an optional long hold-off
   always @(posedge clock) begin
      if (hold_len > 0) begin
         ready_hold_cnt = hold_len;
         hold_len       = 0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (ready_hold_cnt > 0) begin
         ready_hold_cnt--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      rrva_pkg::rsp_payload_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("ERROR: unexpected response status=%0d voice=%0d/%b mask=%h count=%0d",
                        rsp_payload.result_status, rsp_payload.voice_index,
                        rsp_payload.voice_valid, rsp_payload.enable_mask,
                        rsp_payload.active_count);
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_payload.result_status !== exp_rsp.result_status ||
                rsp_payload.voice_index   !== exp_rsp.voice_index   ||
                rsp_payload.voice_valid   !== exp_rsp.voice_valid   ||
                rsp_payload.enable_mask   !== exp_rsp.enable_mask   ||
                rsp_payload.active_count  !== exp_rsp.active_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"ERROR: response mismatch exp status=%0d voice=%0d/%b mask=%h ",
                            "count=%0d, got status=%0d voice=%0d/%b mask=%h count=%0d"},
                           exp_rsp.result_status, exp_rsp.voice_index, exp_rsp.voice_valid,
                           exp_rsp.enable_mask, exp_rsp.active_count,
                           rsp_payload.result_status, rsp_payload.voice_index,
                           rsp_payload.voice_valid, rsp_payload.enable_mask,
                           rsp_payload.active_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int idle_send [4];
      int idle_rsp  [4];
      idle_send = '{0, 48, 0, 17};
      idle_rsp  = '{0, 0, 48, 17};
      for (int v = 0; v < rrva_pkg::VOICES; v++) begin
         voice_on[v]   = 1'b0;
         voice_note[v] = '0;
      end
      last_used  = 0;
      busy_count = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pool, unused opcode, fill to capacity, overflow,
      // duplicate pitch release, miss, refill, free all, release on the empty pool, restart
      queue_request(rrva_pkg::OP_NOTE_OFF, 7'd5);
      queue_request(OP_UNUSED, 7'd127);
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd0);
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd127);
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd60);
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd60);
      for (int p = 10; p < 18; p++)
         queue_request(rrva_pkg::OP_NOTE_ON, rrva_pkg::PITCH_W'(p));
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd99);
      queue_request(rrva_pkg::OP_NOTE_OFF, 7'd60);
      queue_request(rrva_pkg::OP_NOTE_OFF, 7'd42);
      queue_request(rrva_pkg::OP_NOTE_OFF, 7'd127);
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd85);
      queue_request(rrva_pkg::OP_NOTE_OFF, 7'd60);
      queue_request(rrva_pkg::OP_FREE_ALL, 7'd0);
      queue_request(rrva_pkg::OP_NOTE_OFF, 7'd0);
      queue_request(rrva_pkg::OP_NOTE_ON, 7'd3);
      wait_drained();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = idle_send[ph];
         rsp_stall_pct = idle_rsp[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) queue_random_request();
         wait_drained();
      end

      // hold the response side off while requests keep coming
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len      = 300;
      for (int n = 0; n < 40; n++) queue_random_request();
      wait_drained();

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_rsp_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> round_robin_voice_allocator.f
src/rrva_pkg.sv
src/rrva_front.sv
src/rrva_engine.sv
src/round_robin_voice_allocator.sv
sim/round_robin_voice_allocator_tb.sv
